// ----- rtl/flsb_pkg.sv -----
// flsb_pkg: widths, types and register codes for the frustum light-space bounds block
// no dependencies, used by every other file in rtl
package flsb_pkg;

    localparam int COORD_W = 32;
    localparam int VEC_W   = 16;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int DIST_W  = 32;
    localparam int RATIO_W = 16;
    localparam int H_W     = 37;   // half height, unsigned
    localparam int W_W     = 42;   // half width, unsigned
    localparam int CTR_W   = 36;   // plane centre, signed
    localparam int R_W     = 45;   // right/up offsets, signed
    localparam int C_W     = 48;   // corner coordinate, signed
    localparam int P_W     = 64;   // coefficient times corner, signed
    localparam int L_W     = 54;   // light-space coordinate, signed
    localparam int NCORNER = 8;

    typedef enum logic [IDX_W-1:0] {
        REG_LIGHT_ROW_X = 3'd0,
        REG_LIGHT_ROW_Y = 3'd1,
        REG_LIGHT_ROW_Z = 3'd2,
        REG_NEAR_DIST   = 3'd3,
        REG_FAR_DIST    = 3'd4,
        REG_TAN_HALF    = 3'd5,
        REG_ASPECT      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
        logic signed [VEC_W-1:0]   fwd_x, fwd_y, fwd_z;
        logic signed [VEC_W-1:0]   up_x, up_y, up_z;
        logic signed [VEC_W-1:0]   right_x, right_y, right_z;
    } pose_t;

    typedef struct packed {
        logic [DIST_W-1:0]  near_distance;
        logic [DIST_W-1:0]  far_distance;
        logic [RATIO_W-1:0] tan_half_fov;
        logic [RATIO_W-1:0] aspect_ratio;
    } frustum_cfg_t;

    // pipeline control shared by all stages
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

// ----- rtl/flsb_ifs.sv -----
// flsb_pose_if and flsb_box_if: valid/ready channels for camera poses and bounding boxes
// depends on flsb_pkg for field widths
interface flsb_pose_if;
    logic valid;
    logic ready;
    logic signed [flsb_pkg::COORD_W-1:0] pos_x, pos_y, pos_z;
    logic signed [flsb_pkg::VEC_W-1:0]   fwd_x, fwd_y, fwd_z;
    logic signed [flsb_pkg::VEC_W-1:0]   up_x, up_y, up_z;
    logic signed [flsb_pkg::VEC_W-1:0]   right_x, right_y, right_z;
    modport source (output valid, pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z,
                    up_x, up_y, up_z, right_x, right_y, right_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z,
                  up_x, up_y, up_z, right_x, right_y, right_z, output ready);
endinterface

interface flsb_box_if;
    logic valid;
    logic ready;
    logic signed [flsb_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y, min_z, max_z;
    modport source (output valid, min_x, max_x, min_y, max_y, min_z, max_z, input ready);
    modport sink (input valid, min_x, max_x, min_y, max_y, min_z, max_z, output ready);
endinterface

// ----- rtl/flsb_front.sv -----
// flsb_front: four stages from camera pose to the eight world-space frustum corners
// depends on flsb_pkg
module flsb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  flsb_pkg::pipe_ctl_t           ctl,
    input  flsb_pkg::pose_t               pose,
    input  flsb_pkg::frustum_cfg_t        cfg,
    output logic                          valid,
    output logic signed [flsb_pkg::C_W-1:0] corner [flsb_pkg::NCORNER][3]
);
    localparam int C_W   = flsb_pkg::C_W;
    localparam int H_W   = flsb_pkg::H_W;
    localparam int W_W   = flsb_pkg::W_W;
    localparam int CTR_W = flsb_pkg::CTR_W;
    localparam int R_W   = flsb_pkg::R_W;
    localparam int VEC_W = flsb_pkg::VEC_W;
    localparam int COORD_W = flsb_pkg::COORD_W;
    localparam int FP_W  = VEC_W + flsb_pkg::DIST_W + 1;

    logic [3:0] v_reg;

    // stage 1
    logic [H_W-1:0]               h1_reg [2];
    logic signed [FP_W-1:0]       fp1_reg [2][3];
    logic signed [COORD_W-1:0]    pos1_reg [3];
    logic signed [VEC_W-1:0]      up1_reg [3], rt1_reg [3];
    // stage 2
    logic [H_W-1:0]               h2_reg [2];
    logic [W_W-1:0]               w2_reg [2];
    logic signed [CTR_W-1:0]      ctr2_reg [2][3];
    logic signed [VEC_W-1:0]      up2_reg [3], rt2_reg [3];
    // stage 3
    logic signed [CTR_W-1:0]      ctr3_reg [2][3];
    logic signed [R_W-1:0]        r3_reg [2][3], u3_reg [2][3];

    logic [flsb_pkg::DIST_W-1:0]  plane_dist [2];
    logic signed [COORD_W-1:0]    pos_in [3];
    logic signed [VEC_W-1:0]      fwd_in [3], up_in [3], rt_in [3];

    assign plane_dist[0] = cfg.near_distance;
    assign plane_dist[1] = cfg.far_distance;
    assign pos_in = '{pose.pos_x, pose.pos_y, pose.pos_z};
    assign fwd_in = '{pose.fwd_x, pose.fwd_y, pose.fwd_z};
    assign up_in  = '{pose.up_x, pose.up_y, pose.up_z};
    assign rt_in  = '{pose.right_x, pose.right_y, pose.right_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ctl.en)
        begin
            v_reg <= {v_reg[2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int p = 0; p < 2; p++)
            begin
                // half height with round half up
                h1_reg[p] <= H_W'(({17'd0, plane_dist[p]} * {33'd0, cfg.tan_half_fov}
                                   + 49'd2048) >> 12);
                for (int i = 0; i < 3; i++)
                begin
                    fp1_reg[p][i] <= FP_W'(fwd_in[i] * $signed({1'b0, plane_dist[p]}));
                end
            end
            pos1_reg <= pos_in;
            up1_reg  <= up_in;
            rt1_reg  <= rt_in;

            for (int p = 0; p < 2; p++)
            begin
                h2_reg[p] <= h1_reg[p];
                w2_reg[p] <= W_W'(({17'd0, h1_reg[p]} * {38'd0, cfg.aspect_ratio}
                                   + 54'd2048) >> 12);
                for (int i = 0; i < 3; i++)
                begin
                    ctr2_reg[p][i] <= CTR_W'(pos1_reg[i])
                        + CTR_W'((($signed({fp1_reg[p][i][FP_W-1], fp1_reg[p][i]})
                                   + 8192) >>> 14));
                end
            end
            up2_reg <= up1_reg;
            rt2_reg <= rt1_reg;

            for (int p = 0; p < 2; p++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctr3_reg[p][i] <= ctr2_reg[p][i];
                    r3_reg[p][i] <= R_W'(((61'(rt2_reg[i] * $signed({1'b0, w2_reg[p]})))
                                          + 61'sd8192) >>> 14);
                    u3_reg[p][i] <= R_W'(((61'(up2_reg[i] * $signed({1'b0, h2_reg[p]})))
                                          + 61'sd8192) >>> 14);
                end
            end

            // corners per plane: -r+u, +r+u, +r-u, -r-u
            for (int p = 0; p < 2; p++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        corner[p*4+k][i] <= C_W'(ctr3_reg[p][i])
                            + ((k == 1 || k == 2) ? C_W'(r3_reg[p][i]) : -C_W'(r3_reg[p][i]))
                            + ((k < 2) ? C_W'(u3_reg[p][i]) : -C_W'(u3_reg[p][i]));
                    end
                end
            end
        end
    end

    assign valid = v_reg[3];

endmodule

// ----- rtl/flsb_xform.sv -----
// flsb_xform: two stages that map the eight corners through the light-view rows
// depends on flsb_pkg
module flsb_xform #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  flsb_pkg::pipe_ctl_t             ctl,
    input  logic [flsb_pkg::CFG_W-1:0]      row [3],
    input  logic signed [flsb_pkg::C_W-1:0] corner [flsb_pkg::NCORNER][3],
    output logic                            valid,
    output logic signed [flsb_pkg::L_W-1:0] light [flsb_pkg::NCORNER][3]
);
    localparam int P_W = flsb_pkg::P_W;
    localparam int L_W = flsb_pkg::L_W;
    localparam int N   = flsb_pkg::NCORNER;
    localparam int S_W = P_W + 2;

    logic [1:0] v_reg;
    logic signed [P_W-1:0] prod_reg [N][3][3];
    logic signed [S_W-1:0] acc [N][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ctl.en)
        begin
            v_reg <= {v_reg[0], ctl.valid};
        end
    end

    always_comb
    begin
        for (int n = 0; n < N; n++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc[n][a] = S_W'(prod_reg[n][a][0]) + S_W'(prod_reg[n][a][1])
                          + S_W'(prod_reg[n][a][2]) + S_W'(8192);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int n = 0; n < N; n++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        prod_reg[n][a][j] <= P_W'($signed(row[a][16*j +: 16]) * corner[n][j]);
                    end
                    // rounded rotation plus translation scaled to coord format
                    light[n][a] <= L_W'(acc[n][a] >>> 14)
                        + (L_W'($signed(row[a][63:48])) <<< (COORD_FRAC_BITS - 8));
                end
            end
        end
    end

    assign valid = v_reg[1];

endmodule

// ----- rtl/flsb_reduce.sv -----
// flsb_reduce: two stages of min/max over eight corners, with saturation to 32 bits
// depends on flsb_pkg
module flsb_reduce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  flsb_pkg::pipe_ctl_t                 ctl,
    input  logic signed [flsb_pkg::L_W-1:0]     light [flsb_pkg::NCORNER][3],
    output logic                                valid,
    output logic signed [flsb_pkg::COORD_W-1:0] lo [3],
    output logic signed [flsb_pkg::COORD_W-1:0] hi [3]
);
    localparam int L_W = flsb_pkg::L_W;
    localparam int COORD_W = flsb_pkg::COORD_W;
    localparam logic signed [L_W-1:0] SAT_MAX = L_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [L_W-1:0] SAT_MIN = -SAT_MAX - L_W'(1);

    logic [1:0] v_reg;
    logic signed [L_W-1:0] lo_reg [4][3], hi_reg [4][3];
    logic signed [L_W-1:0] lo_a [2][3], hi_a [2][3], lo_f [3], hi_f [3];

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [L_W-1:0] v);
        priority if (v > SAT_MAX)
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < SAT_MIN)
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return v[COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ctl.en)
        begin
            v_reg <= {v_reg[0], ctl.valid};
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int q = 0; q < 2; q++)
            begin
                lo_a[q][a] = (lo_reg[2*q+1][a] < lo_reg[2*q][a]) ? lo_reg[2*q+1][a]
                                                                  : lo_reg[2*q][a];
                hi_a[q][a] = (hi_reg[2*q+1][a] > hi_reg[2*q][a]) ? hi_reg[2*q+1][a]
                                                                  : hi_reg[2*q][a];
            end
            lo_f[a] = (lo_a[1][a] < lo_a[0][a]) ? lo_a[1][a] : lo_a[0][a];
            hi_f[a] = (hi_a[1][a] > hi_a[0][a]) ? hi_a[1][a] : hi_a[0][a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int q = 0; q < 4; q++)
                begin
                    lo_reg[q][a] <= (light[2*q+1][a] < light[2*q][a]) ? light[2*q+1][a]
                                                                      : light[2*q][a];
                    hi_reg[q][a] <= (light[2*q+1][a] > light[2*q][a]) ? light[2*q+1][a]
                                                                      : light[2*q][a];
                end
                lo[a] <= sat(lo_f[a]);
                hi[a] <= sat(hi_f[a]);
            end
        end
    end

    assign valid = v_reg[1];

endmodule

// ----- rtl/frustum_light_space_bounds.sv -----
// frustum_light_space_bounds: top level, config registers and the eight-stage pipeline
// depends on flsb_pkg, flsb_ifs, flsb_front, flsb_xform and flsb_reduce

// Light-space bounding box of a camera frustum slice for shadow map fitting. Each
// transfer on pose carries a camera position and forward, up and right vectors; at
// the end of the pipeline one transfer on box carries the per-axis minimum and
// maximum of the eight slice corners after the light-view transform. The pipeline
// takes one pose every cycle while no finished box is held; the eight stages are:
// half height and forward products, half width and plane centres, right/up offsets,
// corners, coefficient products, row sums with translation, pairwise extremes, final
// extremes with saturation. All stages advance together on one enable that drops
// only while a finished box waits on box.ready, so a stall holds every item in place.
// Configuration is written through cfg_we/cfg_index/cfg_data, by the user only while
// the pipeline is empty (the block does not enforce it); higher indexes are ignored.
module frustum_light_space_bounds #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [flsb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [flsb_pkg::CFG_W-1:0]    cfg_data,
    flsb_pose_if.sink                     pose,
    flsb_box_if.source                    box
);
    // configuration registers
    logic [flsb_pkg::CFG_W-1:0] row_reg [3];
    flsb_pkg::frustum_cfg_t     fcfg_reg;

    flsb_pkg::pipe_ctl_t ctl_front, ctl_xform, ctl_reduce;
    flsb_pkg::pose_t     pose_in;
    logic                en;
    logic                v_front, v_xform, v_reduce;

    logic signed [flsb_pkg::C_W-1:0]     corner [flsb_pkg::NCORNER][3];
    logic signed [flsb_pkg::L_W-1:0]     light  [flsb_pkg::NCORNER][3];
    logic signed [flsb_pkg::COORD_W-1:0] lo [3], hi [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
            fcfg_reg.near_distance <= 32'd65536;
            fcfg_reg.far_distance  <= 32'd6553600;
            fcfg_reg.tan_half_fov  <= 16'd4096;
            fcfg_reg.aspect_ratio  <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                flsb_pkg::REG_LIGHT_ROW_X: row_reg[0] <= cfg_data;
                flsb_pkg::REG_LIGHT_ROW_Y: row_reg[1] <= cfg_data;
                flsb_pkg::REG_LIGHT_ROW_Z: row_reg[2] <= cfg_data;
                flsb_pkg::REG_NEAR_DIST:   fcfg_reg.near_distance <= cfg_data[31:0];
                flsb_pkg::REG_FAR_DIST:    fcfg_reg.far_distance  <= cfg_data[31:0];
                flsb_pkg::REG_TAN_HALF:    fcfg_reg.tan_half_fov  <= cfg_data[15:0];
                flsb_pkg::REG_ASPECT:      fcfg_reg.aspect_ratio  <= cfg_data[15:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // whole pipe moves unless the output box is held
    assign en = !v_reduce || box.ready;
    assign pose.ready = en;

    assign pose_in = '{pos_x: pose.pos_x, pos_y: pose.pos_y, pos_z: pose.pos_z,
                       fwd_x: pose.fwd_x, fwd_y: pose.fwd_y, fwd_z: pose.fwd_z,
                       up_x: pose.up_x, up_y: pose.up_y, up_z: pose.up_z,
                       right_x: pose.right_x, right_y: pose.right_y,
                       right_z: pose.right_z};

    assign ctl_front  = '{en: en, valid: pose.valid};
    assign ctl_xform  = '{en: en, valid: v_front};
    assign ctl_reduce = '{en: en, valid: v_xform};

    // stages 1-4: world-space corners
    flsb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_front),
        .pose   (pose_in),
        .cfg    (fcfg_reg),
        .valid  (v_front),
        .corner (corner)
    );

    // stages 5-6: light-view transform
    flsb_xform #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_xform (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_xform),
        .row    (row_reg),
        .corner (corner),
        .valid  (v_xform),
        .light  (light)
    );

    // stages 7-8: extremes, final stage is the output register
    flsb_reduce u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_reduce),
        .light  (light),
        .valid  (v_reduce),
        .lo     (lo),
        .hi     (hi)
    );

    assign box.valid = v_reduce;
    assign box.min_x = lo[0];
    assign box.max_x = hi[0];
    assign box.min_y = lo[1];
    assign box.max_y = hi[1];
    assign box.min_z = lo[2];
    assign box.max_z = hi[2];

endmodule
